>>> rtl/linear_blend_skinning_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the skinning engine
// Both macros sample on clk and stay quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH

// Same-cycle implication
`define LBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lbs_pkg.sv
// ---------------------------------------------------------------------------
// lbs_pkg
// Shared constants, codes and controller/datapath bundles of the skinning
// engine.
// ---------------------------------------------------------------------------
package lbs_pkg;

  localparam int MAX_JOINTS_DEF = 32;
  localparam int INFLUENCES_DEF = 4;
  localparam int FIELD_INF      = 4;   // influences carried by one vertex item
  localparam int ROW_ELEMS      = 12;  // words of one 3x4 matrix

  localparam int JC_W      = 6;
  localparam int JC_RESET  = 26;
  localparam int SLOT_W    = 9;
  localparam int WORD_W    = 32;
  localparam int NRM_OUT_W = 18;
  localparam int Q_W       = 17;   // normal quotient magnitude
  localparam int T_W       = 50;   // per-influence row sum
  localparam int ACC_W     = 56;   // weighted sums over all influences
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam int IN_DATA_W  = 336;
  localparam int OUT_DATA_W = 152;

  // input tdata layout
  localparam int OFS_SLOT    = 0;
  localparam int OFS_VALUE   = 9;
  localparam int OFS_BX      = 41;
  localparam int OFS_BY      = 73;
  localparam int OFS_BZ      = 105;
  localparam int OFS_BNX     = 137;
  localparam int OFS_BNY     = 169;
  localparam int OFS_BNZ     = 201;
  localparam int OFS_JOINTS  = 233;
  localparam int OFS_WEIGHTS = 265;

  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MUL_NONE = 3'd0;
  localparam mul_op_t MUL_EP   = 3'd1;  // matrix element times position
  localparam mul_op_t MUL_EN   = 3'd2;  // matrix element times normal
  localparam mul_op_t MUL_WL   = 3'd3;  // low 16 bits of row sum times weight
  localparam mul_op_t MUL_WH   = 3'd4;  // high part of row sum times weight
  localparam mul_op_t MUL_SQ   = 3'd5;  // magnitude squared

  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_NONE = 2'd0;
  localparam acc_op_t ACC_FRAC = 2'd1;  // add product rounded to Q16.16
  localparam acc_op_t ACC_FULL = 2'd2;  // add product as is
  localparam acc_op_t ACC_ELEM = 2'd3;  // add translation element

  typedef logic [1:0] acc_dst_t;
  localparam acc_dst_t DST_TP  = 2'd0;
  localparam acc_dst_t DST_TN  = 2'd1;
  localparam acc_dst_t DST_POS = 2'd2;
  localparam acc_dst_t DST_NRM = 2'd3;

  typedef struct packed {
    logic     wr_en;
    logic     load_v;
    logic     clr_acc;
    logic     clr_t;
    logic     rd_en;
    logic [1:0] inf;
    logic [1:0] col;
    logic [1:0] row;
    mul_op_t  mul_op;
    acc_op_t  acc_op;
    acc_dst_t acc_dst;
    logic     wsrc_n;
    logic     norm_ld;
    logic     norm_shr;
    logic     norm_shl;
    logic     sq_acc;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     div_store;
    logic     un_zero;
    logic [1:0] comp;
    logic     out_load;
  } lbs_cmd_t;

  typedef struct packed {
    logic [7:0] inf_j;
    logic       inf_wz;
    logic       mag_zero;
    logic       mag_hi;
    logic       mag_lo;
    logic       sqrt_done;
    logic       out_full;
  } lbs_sts_t;

endpackage

>>> rtl/lbs_ctrl.sv
// ---------------------------------------------------------------------------
// lbs_ctrl
// Sequencer of the skinning engine: walks influences, rows and columns,
// then the normalize steps, and drives the datapath by command.
// ---------------------------------------------------------------------------
module lbs_ctrl #(
  parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
  parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF,
  localparam int DEPTH = MAX_JOINTS * lbs_pkg::ROW_ELEMS,
  localparam int AW    = $clog2(DEPTH),
  localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_mode,
  output logic                    in_tready,
  input  logic                    cfg_wr_en,
  input  logic [lbs_pkg::JC_W-1:0] cfg_wr_data,
  input  lbs_pkg::lbs_sts_t       sts,
  output lbs_pkg::lbs_cmd_t       cmd,
  output logic [AW-1:0]           rd_addr
);

  localparam int NI = (INFLUENCES < lbs_pkg::FIELD_INF) ? INFLUENCES : lbs_pkg::FIELD_INF;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SEL  = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_MEP  = 5'd3;
  localparam logic [4:0] S_MEN  = 5'd4;
  localparam logic [4:0] S_ATN  = 5'd5;
  localparam logic [4:0] S_ATR  = 5'd6;
  localparam logic [4:0] S_WLP  = 5'd7;
  localparam logic [4:0] S_WHP  = 5'd8;
  localparam logic [4:0] S_WLN  = 5'd9;
  localparam logic [4:0] S_WHN  = 5'd10;
  localparam logic [4:0] S_WFN  = 5'd11;
  localparam logic [4:0] S_NLD  = 5'd12;
  localparam logic [4:0] S_NCHK = 5'd13;
  localparam logic [4:0] S_SQ   = 5'd14;
  localparam logic [4:0] S_SQE  = 5'd15;
  localparam logic [4:0] S_SQRT = 5'd16;
  localparam logic [4:0] S_DVI  = 5'd17;
  localparam logic [4:0] S_DV   = 5'd18;
  localparam logic [4:0] S_DVE  = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  localparam logic [4:0] DIV_LAST = 5'(lbs_pkg::Q_W - 1);

  logic [4:0] state_r, state_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] r_r, r_nxt;
  logic [1:0] c_r, c_nxt;
  logic [1:0] k_r, k_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [lbs_pkg::JC_W-1:0] jc_r;
  logic inf_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      jc_r    <= lbs_pkg::JC_W'(lbs_pkg::JC_RESET);
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) jc_r <= cfg_wr_data;
    end
    i_r   <= i_nxt;
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    j_r   <= j_nxt;
  end

  assign inf_ok = !sts.inf_wz && !sts.inf_j[7] &&
                  ({1'b0, sts.inf_j[6:0]} < {2'b0, jc_r}) &&
                  (int'(sts.inf_j[6:0]) < MAX_JOINTS);

  assign in_tready = (state_r == S_IDLE);
  assign rd_addr   = AW'(int'(j_r) * lbs_pkg::ROW_ELEMS + int'(r_r) * 4 + int'(c_r));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.inf   = i_r;
    cmd.col   = c_r;
    cmd.row   = r_r;
    cmd.comp  = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && !in_mode) cmd.wr_en = 1'b1;
        if (in_tvalid && in_mode) begin
          cmd.load_v  = 1'b1;
          cmd.clr_acc = 1'b1;
          i_nxt       = 2'd0;
          state_nxt   = S_SEL;
        end
      end
      S_SEL: begin
        cmd.inf = i_r;
        if (inf_ok) begin
          j_nxt     = JW'(sts.inf_j[6:0]);
          r_nxt     = 2'd0;
          c_nxt     = 2'd0;
          state_nxt = S_RD;
        end else if (int'(i_r) == NI - 1) begin
          state_nxt = S_NLD;
        end else begin
          i_nxt = i_r + 2'd1;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        cmd.clr_t = (c_r == 2'd0);
        state_nxt = (c_r == 2'd3) ? S_ATR : S_MEP;
      end
      S_MEP: begin
        cmd.mul_op = lbs_pkg::MUL_EP;
        state_nxt  = S_MEN;
      end
      S_MEN: begin
        cmd.acc_op  = lbs_pkg::ACC_FRAC;
        cmd.acc_dst = lbs_pkg::DST_TP;
        cmd.mul_op  = lbs_pkg::MUL_EN;
        state_nxt   = S_ATN;
      end
      S_ATN: begin
        cmd.acc_op  = lbs_pkg::ACC_FRAC;
        cmd.acc_dst = lbs_pkg::DST_TN;
        c_nxt       = c_r + 2'd1;
        state_nxt   = S_RD;
      end
      S_ATR: begin
        cmd.acc_op  = lbs_pkg::ACC_ELEM;
        cmd.acc_dst = lbs_pkg::DST_TP;
        state_nxt   = S_WLP;
      end
      S_WLP: begin
        cmd.mul_op = lbs_pkg::MUL_WL;
        state_nxt  = S_WHP;
      end
      S_WHP: begin
        cmd.acc_op  = lbs_pkg::ACC_FRAC;
        cmd.acc_dst = lbs_pkg::DST_POS;
        cmd.mul_op  = lbs_pkg::MUL_WH;
        state_nxt   = S_WLN;
      end
      S_WLN: begin
        cmd.acc_op  = lbs_pkg::ACC_FULL;
        cmd.acc_dst = lbs_pkg::DST_POS;
        cmd.mul_op  = lbs_pkg::MUL_WL;
        cmd.wsrc_n  = 1'b1;
        state_nxt   = S_WHN;
      end
      S_WHN: begin
        cmd.acc_op  = lbs_pkg::ACC_FRAC;
        cmd.acc_dst = lbs_pkg::DST_NRM;
        cmd.mul_op  = lbs_pkg::MUL_WH;
        cmd.wsrc_n  = 1'b1;
        state_nxt   = S_WFN;
      end
      S_WFN: begin
        cmd.acc_op  = lbs_pkg::ACC_FULL;
        cmd.acc_dst = lbs_pkg::DST_NRM;
        if (r_r != 2'd2) begin
          r_nxt     = r_r + 2'd1;
          c_nxt     = 2'd0;
          state_nxt = S_RD;
        end else if (int'(i_r) == NI - 1) begin
          state_nxt = S_NLD;
        end else begin
          i_nxt     = i_r + 2'd1;
          state_nxt = S_SEL;
        end
      end
      S_NLD: begin
        cmd.norm_ld = 1'b1;
        state_nxt   = S_NCHK;
      end
      S_NCHK: begin
        if (sts.mag_zero) begin
          cmd.un_zero = 1'b1;
          state_nxt   = S_OUT;
        end else if (sts.mag_hi) begin
          cmd.norm_shr = 1'b1;
        end else if (sts.mag_lo) begin
          cmd.norm_shl = 1'b1;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_op = lbs_pkg::MUL_SQ;
        cmd.sq_acc = (k_r != 2'd0);
        if (k_r == 2'd2) state_nxt = S_SQE;
        else k_nxt = k_r + 2'd1;
      end
      S_SQE: begin
        cmd.sq_acc = 1'b1;
        state_nxt  = S_SQRT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          k_nxt     = 2'd0;
          state_nxt = S_DVI;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = 5'd0;
        state_nxt    = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_DVE;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_DVE: begin
        cmd.div_store = 1'b1;
        if (k_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DVI;
        end
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/lbs_dp.sv
// ---------------------------------------------------------------------------
// lbs_dp
// Datapath of the skinning engine: matrix store, shared multiplier,
// accumulators, normalize shifter, square root, divider, output register.
// ---------------------------------------------------------------------------
module lbs_dp #(
  parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
  localparam int DEPTH = MAX_JOINTS * lbs_pkg::ROW_ELEMS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lbs_pkg::lbs_cmd_t              cmd,
  output lbs_pkg::lbs_sts_t              sts,
  input  logic [AW-1:0]                  rd_addr,
  input  logic [lbs_pkg::SLOT_W-1:0]     matrix_slot,
  input  logic signed [31:0]             matrix_value,
  input  logic signed [31:0]             bind_x,
  input  logic signed [31:0]             bind_y,
  input  logic signed [31:0]             bind_z,
  input  logic signed [31:0]             bind_nx,
  input  logic signed [31:0]             bind_ny,
  input  logic signed [31:0]             bind_nz,
  input  logic [31:0]                    influence_joints,
  input  logic [63:0]                    influence_weights,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic signed [31:0]             skinned_x,
  output logic signed [31:0]             skinned_y,
  output logic signed [31:0]             skinned_z,
  output logic signed [lbs_pkg::NRM_OUT_W-1:0] skinned_nx,
  output logic signed [lbs_pkg::NRM_OUT_W-1:0] skinned_ny,
  output logic signed [lbs_pkg::NRM_OUT_W-1:0] skinned_nz
);

  localparam int T_W    = lbs_pkg::T_W;
  localparam int ACC_W  = lbs_pkg::ACC_W;
  localparam int PW     = lbs_pkg::PROD_W;
  localparam int NW     = lbs_pkg::NRM_OUT_W;
  localparam int QW     = lbs_pkg::Q_W;

  logic [31:0]        mem [DEPTH];
  logic signed [31:0] rdata_r;

  logic signed [31:0] p_r [3];
  logic signed [31:0] n_r [3];
  logic [31:0]        joints_r;
  logic [63:0]        weights_r;
  logic [15:0]        w_r;

  logic signed [T_W-1:0]   tp_r, tn_r, tsel;
  logic signed [ACC_W-1:0] pos_r [3];
  logic signed [ACC_W-1:0] nrm_r [3];

  logic signed [lbs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lbs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0] prod, prod_r, rnd, addend;

  logic [ACC_W-1:0] mag_r [3];
  logic [63:0]      v_r, res_r, bit_r, root_try;
  logic [31:0]      len;
  logic [46:0]      num;
  logic [31:0]      rem_r, div_try;
  logic [QW-1:0]    nsh_r, q_r;
  logic signed [NW-1:0] un_r [3];

  logic             out_valid_r;
  logic [31:0]      ox_r, oy_r, oz_r;
  logic [NW-1:0]    onx_r, ony_r, onz_r;

  // matrix store
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (int'(matrix_slot) < DEPTH)) mem[AW'(matrix_slot)] <= matrix_value;
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  // vertex capture and influence select
  always_ff @(posedge clk) begin
    if (cmd.load_v) begin
      p_r[0]    <= bind_x;
      p_r[1]    <= bind_y;
      p_r[2]    <= bind_z;
      n_r[0]    <= bind_nx;
      n_r[1]    <= bind_ny;
      n_r[2]    <= bind_nz;
      joints_r  <= influence_joints;
      weights_r <= influence_weights;
    end
    if (cmd.inf == cmd.inf && cmd.load_v == 1'b0) w_r <= weights_r[16*cmd.inf +: 16];
  end

  assign sts.inf_j  = joints_r[8*cmd.inf +: 8];
  assign sts.inf_wz = (weights_r[16*cmd.inf +: 16] == 16'd0);

  // shared multiplier
  assign tsel = cmd.wsrc_n ? tn_r : tp_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      lbs_pkg::MUL_EP: begin
        mul_a = lbs_pkg::MUL_A_W'(rdata_r);
        mul_b = lbs_pkg::MUL_B_W'(p_r[cmd.col]);
      end
      lbs_pkg::MUL_EN: begin
        mul_a = lbs_pkg::MUL_A_W'(rdata_r);
        mul_b = lbs_pkg::MUL_B_W'(n_r[cmd.col]);
      end
      lbs_pkg::MUL_WL: begin
        mul_a = {18'b0, tsel[15:0]};
        mul_b = {17'b0, w_r};
      end
      lbs_pkg::MUL_WH: begin
        mul_a = lbs_pkg::MUL_A_W'(tsel >>> 16);
        mul_b = {17'b0, w_r};
      end
      lbs_pkg::MUL_SQ: begin
        mul_a = {4'b0, mag_r[cmd.comp][29:0]};
        mul_b = {3'b0, mag_r[cmd.comp][29:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign rnd  = (prod_r + PW'(32768)) >>> 16;

  always_comb begin
    case (cmd.acc_op)
      lbs_pkg::ACC_FRAC: addend = rnd;
      lbs_pkg::ACC_FULL: addend = prod_r;
      lbs_pkg::ACC_ELEM: addend = PW'(rdata_r);
      default:           addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != lbs_pkg::MUL_NONE) prod_r <= prod;
  end

  // row sums and weighted accumulators
  always_ff @(posedge clk) begin
    if (cmd.clr_t) begin
      tp_r <= '0;
      tn_r <= '0;
    end else if (cmd.acc_op != lbs_pkg::ACC_NONE) begin
      if (cmd.acc_dst == lbs_pkg::DST_TP) tp_r <= tp_r + T_W'(addend);
      if (cmd.acc_dst == lbs_pkg::DST_TN) tn_r <= tn_r + T_W'(addend);
    end
    if (cmd.clr_acc) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        nrm_r[i] <= '0;
      end
    end else if (cmd.acc_op != lbs_pkg::ACC_NONE) begin
      if (cmd.acc_dst == lbs_pkg::DST_POS) pos_r[cmd.row] <= pos_r[cmd.row] + ACC_W'(addend);
      if (cmd.acc_dst == lbs_pkg::DST_NRM) nrm_r[cmd.row] <= nrm_r[cmd.row] + ACC_W'(addend);
    end
  end

  // normalize: scale so the largest magnitude lies in [2^29, 2^30), one bit a cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.norm_ld) mag_r[i] <= nrm_r[i][ACC_W-1] ? ACC_W'(-nrm_r[i]) : ACC_W'(nrm_r[i]);
      else if (cmd.norm_shr) mag_r[i] <= mag_r[i] >> 1;
      else if (cmd.norm_shl) mag_r[i] <= mag_r[i] << 1;
    end
  end

  always_comb begin
    sts.mag_zero = 1'b1;
    sts.mag_hi   = 1'b0;
    sts.mag_lo   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (mag_r[i] != '0) sts.mag_zero = 1'b0;
      if (mag_r[i][ACC_W-1:30] != '0) sts.mag_hi = 1'b1;
      if (mag_r[i][ACC_W-1:29] != '0) sts.mag_lo = 1'b0;
    end
  end

  // sum of squares and bitwise square root
  assign root_try = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.norm_ld) begin
      v_r   <= '0;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sq_acc) begin
      v_r <= v_r + prod_r[63:0];
    end else if (cmd.sqrt_step) begin
      if (v_r >= root_try) begin
        v_r   <= v_r - root_try;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign sts.sqrt_done = (bit_r == '0);

  // restoring divider, one quotient bit a cycle
  assign len     = res_r[31:0];
  assign num     = {1'b0, mag_r[cmd.comp][29:0], 16'b0} + 47'(len >> 1);
  assign div_try = {rem_r[30:0], nsh_r[QW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= 32'(num[46:QW]);
      nsh_r <= num[QW-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (div_try >= len) begin
        rem_r <= div_try - len;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= div_try;
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      nsh_r <= {nsh_r[QW-2:0], 1'b0};
    end
    if (cmd.un_zero) begin
      for (int i = 0; i < 3; i++) un_r[i] <= '0;
    end else if (cmd.div_store) begin
      un_r[cmd.comp] <= nrm_r[cmd.comp][ACC_W-1] ? NW'(0) - NW'(q_r) : NW'(q_r);
    end
  end

  // output register
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if ((v[ACC_W-1:31] == '0) || (v[ACC_W-1:31] == '1)) r = v[31:0];
    else r = v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      ox_r  <= sat32(pos_r[0]);
      oy_r  <= sat32(pos_r[1]);
      oz_r  <= sat32(pos_r[2]);
      onx_r <= un_r[0];
      ony_r <= un_r[1];
      onz_r <= un_r[2];
    end
  end

  assign sts.out_full = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign skinned_x    = ox_r;
  assign skinned_y    = oy_r;
  assign skinned_z    = oz_r;
  assign skinned_nx   = onx_r;
  assign skinned_ny   = ony_r;
  assign skinned_nz   = onz_r;

endmodule

>>> rtl/linear_blend_skinning.sv
// ---------------------------------------------------------------------------
// linear_blend_skinning
// Four-influence linear blend skinning engine, Q16.16 fixed point.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: mode; tdata: load or vertex fields
// out_     out  out_tvalid/out_tready tdata: skinned position and unit normal
// cfg_     in   cfg_wr_en             cfg_wr_data: joint_count
//
// A load item writes the matrix store directly.
// A vertex item's time grows with each valid influence and each normalize
// shift; the single shared multiplier, the 32-step square root and the
// three 17-step divides set it.
// Reset (rst_n low, synchronous) clears control state and sets joint_count
// to 26; the matrix store holds garbage until written.
// A finished result waits in the output register; the next item is taken
// while it waits, and only a second vertex result stalls on it.
// ---------------------------------------------------------------------------
`include "linear_blend_skinning_assert.svh"

module linear_blend_skinning #(
  parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
  parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] mode
  input  logic                              in_tuser,
  // matrix_slot, matrix_value, bind_x, bind_y, bind_z, bind_nx, bind_ny,
  // bind_nz, influence_joints, influence_weights, zero pad
  input  logic [lbs_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // skinned_x, skinned_y, skinned_z, skinned_nx, skinned_ny, skinned_nz,
  // zero pad
  output logic [lbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [lbs_pkg::JC_W-1:0]          cfg_wr_data
);

  localparam int DEPTH = MAX_JOINTS * lbs_pkg::ROW_ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = lbs_pkg::NRM_OUT_W;

  lbs_pkg::lbs_cmd_t cmd;
  lbs_pkg::lbs_sts_t sts;
  logic [AW-1:0]     rd_addr;

  logic signed [31:0]  sk_x, sk_y, sk_z;
  logic signed [NW-1:0] sk_nx, sk_ny, sk_nz;

  // sequencer: influence walk, row/column walk, normalize steps
  lbs_ctrl #(
    .MAX_JOINTS (MAX_JOINTS),
    .INFLUENCES (INFLUENCES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_mode     (in_tuser),
    .in_tready   (in_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  // datapath: unpack fields straight from tdata
  lbs_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .rd_addr           (rd_addr),
    .matrix_slot       (in_tdata[lbs_pkg::OFS_SLOT +: lbs_pkg::SLOT_W]),
    .matrix_value      (in_tdata[lbs_pkg::OFS_VALUE +: 32]),
    .bind_x            (in_tdata[lbs_pkg::OFS_BX +: 32]),
    .bind_y            (in_tdata[lbs_pkg::OFS_BY +: 32]),
    .bind_z            (in_tdata[lbs_pkg::OFS_BZ +: 32]),
    .bind_nx           (in_tdata[lbs_pkg::OFS_BNX +: 32]),
    .bind_ny           (in_tdata[lbs_pkg::OFS_BNY +: 32]),
    .bind_nz           (in_tdata[lbs_pkg::OFS_BNZ +: 32]),
    .influence_joints  (in_tdata[lbs_pkg::OFS_JOINTS +: 32]),
    .influence_weights (in_tdata[lbs_pkg::OFS_WEIGHTS +: 64]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .skinned_x         (sk_x),
    .skinned_y         (sk_y),
    .skinned_z         (sk_z),
    .skinned_nx        (sk_nx),
    .skinned_ny        (sk_ny),
    .skinned_nz        (sk_nz)
  );

  // pack result, position words first
  assign out_tdata = {2'b0, sk_nz, sk_ny, sk_nx, sk_z, sk_y, sk_x};

  // a vertex item leaves the sequencer busy after it is taken
  `LBS_ASSERT_NEXT(a_vertex_busy, in_tvalid && in_tready && in_tuser, !in_tready,
    "vertex item did not make the engine busy")
  // a load item finishes in its own cycle
  `LBS_ASSERT_NEXT(a_load_single, in_tvalid && in_tready && !in_tuser, in_tready,
    "load item held the engine busy")
  // x and z components of the unit normal stay within one in magnitude
  `LBS_ASSERT_NOW(a_norm_range, out_tvalid,
    ($signed(sk_nx) <= 18'sd65536) && ($signed(sk_nx) >= -18'sd65536) &&
    ($signed(sk_nz) <= 18'sd65536) && ($signed(sk_nz) >= -18'sd65536),
    "normal component out of unit range")

endmodule
